// File: src/eadcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eadcm_pkg
// Shared types, constants and CORDIC arctangent table for the Euler angle to
// direction cosine matrix unit.
// ----------------------------------------------------------------------------
package eadcm_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int FRACTION_BITS = 14;
  localparam int CORDIC_STAGES = 16;
  localparam int WORK_BITS     = 30;
  localparam int ELEM_BITS     = FRACTION_BITS + 2;
  localparam int CW            = 34;
  localparam int ZW            = 33;
  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
  localparam logic signed [ELEM_BITS-1:0] ONE_Q = ELEM_BITS'(1 << FRACTION_BITS);
  localparam int QDEPTH = 4;
  localparam int QPW    = 2;

  localparam logic [1:0] AXIS_NONE = 2'd0;
  localparam logic [1:0] AXIS_X    = 2'd1;
  localparam logic [1:0] AXIS_Y    = 2'd2;
  localparam logic [1:0] AXIS_Z    = 2'd3;

  localparam logic [1:0] REG_FIRST  = 2'd0;
  localparam logic [1:0] REG_SECOND = 2'd1;
  localparam logic [1:0] REG_THIRD  = 2'd2;

  typedef logic signed [ELEM_BITS-1:0] elem_t;

  typedef struct packed {
    logic [15:0] angle_one;
    logic [15:0] angle_two;
    logic [15:0] angle_three;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] elem_r0c0;
    logic signed [15:0] elem_r0c1;
    logic signed [15:0] elem_r0c2;
    logic signed [15:0] elem_r1c0;
    logic signed [15:0] elem_r1c1;
    logic signed [15:0] elem_r1c2;
    logic signed [15:0] elem_r2c0;
    logic signed [15:0] elem_r2c1;
    logic signed [15:0] elem_r2c2;
  } out_item_t;

  typedef struct packed {
    logic [1:0] axis;
    elem_t      c;
    elem_t      s;
  } rot_t;

  typedef struct packed {
    rot_t r0;
    rot_t r1;
    rot_t r2;
  } cmd_t;

  typedef elem_t [8:0] mat_t;

  function automatic logic [31:0] atan_lut(input int i);
    logic [31:0] t;
    unique case (i)
      0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
      3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
      9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2F9;
      15: t = 32'h0000517C; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A2F; 19: t = 32'h00000517; 20: t = 32'h0000028B;
      21: t = 32'h00000145; 22: t = 32'h000000A2; 23: t = 32'h00000051;
      24: t = 32'h00000028; 25: t = 32'h00000014; 26: t = 32'h0000000A;
      27: t = 32'h00000005; 28: t = 32'h00000002; 29: t = 32'h00000001;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

  // round half up by s bits, then clamp to +/- one
  function automatic elem_t round_clamp(input logic signed [35:0] v, input int s);
    logic signed [35:0] r;
    r = (v + (36'sd1 <<< (s - 1))) >>> s;
    if (r > 36'(ONE_Q)) return ONE_Q;
    if (r < -36'(ONE_Q)) return -ONE_Q;
    return r[ELEM_BITS-1:0];
  endfunction

endpackage

// File: src/euler_angles_to_rotation_matrix_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_matrix_unit
// Three binary angles to a 3x3 frame-rotation direction cosine matrix.
// ----------------------------------------------------------------------------
// An item is taken on every cycle that start is high; busy stays low. Each
// item's matrix appears on out_ with out_strobe for one cycle. The path
// holds 22 register stages, the first loaded at acceptance: 18 in the
// three parallel CORDIC pipelines, one in the command queue, three in the
// matrix stages (elementary matrix, then two multiplies). The receiver
// cannot stall; results keep input order. Axis registers are sampled at
// acceptance.
module euler_angles_to_rotation_matrix_unit
  import eadcm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_item,
  output logic       out_strobe,
  output out_item_t  out_item,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [1:0] cfg_data
);

  logic [1:0] axis0_r, axis1_r, axis2_r;
  logic fv, qv;
  cmd_t fcmd, qcmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis0_r <= AXIS_Z;
      axis1_r <= AXIS_X;
      axis2_r <= AXIS_Z;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST:  axis0_r <= cfg_data;
        REG_SECOND: axis1_r <= cfg_data;
        REG_THIRD:  axis2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  eadcm_front u_front (.clk, .rst_n, .in_vld(start && !busy), .in_item,
                       .axis0(axis0_r), .axis1(axis1_r), .axis2(axis2_r),
                       .cmd_vld(fv), .cmd(fcmd));

  eadcm_queue u_queue (.clk, .rst_n, .wr_en(fv), .wr_data(fcmd),
                       .rd_en(1'b1), .rd_vld(qv), .rd_data(qcmd));

  eadcm_back u_back (.clk, .rst_n, .cmd_vld(qv), .cmd(qcmd),
                     .out_vld(out_strobe), .out_item);

`ifndef SYNTH
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    fv |=> qv) else $error("queue lost a command");
  a_nobusy: assert property (@(posedge clk) !busy) else $error("busy raised");
`endif

endmodule

// File: src/eadcm_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eadcm_sincos
// Pipelined CORDIC: one binary angle per cycle in, cosine and sine out.
// ----------------------------------------------------------------------------
module eadcm_sincos
  import eadcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [15:0] in_angle,
  output logic        out_vld,
  output elem_t       out_cos,
  output elem_t       out_sin
);

  logic signed [CW-1:0] x_r [CORDIC_STAGES+1];
  logic signed [CW-1:0] y_r [CORDIC_STAGES+1];
  logic signed [ZW-1:0] z_r [CORDIC_STAGES+1];
  logic [CORDIC_STAGES:0] flip_r;
  logic [CORDIC_STAGES+1:0] vld_r;
  logic [31:0] phase, ph2;
  logic fl;
  elem_t cos_r, sin_r;

  always_comb begin
    phase = {in_angle[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
    fl = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
    ph2 = fl ? phase + 32'h80000000 : phase;
  end

  always_ff @(posedge clk) begin
    x_r[0] <= CORDIC_GAIN;
    y_r[0] <= '0;
    z_r[0] <= ZW'($signed(ph2));
    flip_r[0] <= fl;
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!z_r[i][ZW-1]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - ZW'(atan_lut(i));
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + ZW'(atan_lut(i));
      end
      flip_r[i+1] <= flip_r[i];
    end
  end

  always_ff @(posedge clk) begin
    cos_r <= flip_r[CORDIC_STAGES]
      ? -round_clamp(36'(x_r[CORDIC_STAGES]), WORK_BITS - FRACTION_BITS)
      :  round_clamp(36'(x_r[CORDIC_STAGES]), WORK_BITS - FRACTION_BITS);
    sin_r <= flip_r[CORDIC_STAGES]
      ? -round_clamp(36'(y_r[CORDIC_STAGES]), WORK_BITS - FRACTION_BITS)
      :  round_clamp(36'(y_r[CORDIC_STAGES]), WORK_BITS - FRACTION_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[CORDIC_STAGES:0], in_vld};
    end
  end

  assign out_vld = vld_r[CORDIC_STAGES+1];
  assign out_cos = cos_r;
  assign out_sin = sin_r;

endmodule

// File: src/eadcm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eadcm_front
// Accepts angle items, tags each step with its axis and computes sin/cos.
// ----------------------------------------------------------------------------
module eadcm_front
  import eadcm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_vld,
  input  in_item_t   in_item,
  input  logic [1:0] axis0,
  input  logic [1:0] axis1,
  input  logic [1:0] axis2,
  output logic       cmd_vld,
  output cmd_t       cmd
);

  localparam int LAT = CORDIC_STAGES + 2;

  logic [5:0] ax_r [LAT];
  logic v0, v1, v2;
  elem_t c0, s0, c1, s1, c2, s2;

  always_ff @(posedge clk) begin
    ax_r[0] <= {axis0, axis1, axis2};
    for (int i = 1; i < LAT; i++) ax_r[i] <= ax_r[i-1];
  end

  eadcm_sincos u_sc0 (.clk, .rst_n, .in_vld(in_vld), .in_angle(in_item.angle_one),
                      .out_vld(v0), .out_cos(c0), .out_sin(s0));
  eadcm_sincos u_sc1 (.clk, .rst_n, .in_vld(in_vld), .in_angle(in_item.angle_two),
                      .out_vld(v1), .out_cos(c1), .out_sin(s1));
  eadcm_sincos u_sc2 (.clk, .rst_n, .in_vld(in_vld), .in_angle(in_item.angle_three),
                      .out_vld(v2), .out_cos(c2), .out_sin(s2));

  assign cmd_vld = v0 & v1 & v2;
  assign cmd = '{r0: '{axis: ax_r[LAT-1][5:4], c: c0, s: s0},
                 r1: '{axis: ax_r[LAT-1][3:2], c: c1, s: s1},
                 r2: '{axis: ax_r[LAT-1][1:0], c: c2, s: s2}};

endmodule

// File: src/eadcm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eadcm_queue
// Short FIFO of rotation commands between front and back.
// ----------------------------------------------------------------------------
module eadcm_queue
  import eadcm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_data,
  input  logic rd_en,
  output logic rd_vld,
  output cmd_t rd_data
);

  cmd_t mem_r [QDEPTH];
  logic [QPW-1:0] wp_r, rp_r;
  logic [QPW:0] cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en && rd_vld) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPW+1)'(wr_en) - (QPW+1)'(rd_en && rd_vld);
    end
  end

  assign rd_vld = cnt_r != '0;
  assign rd_data = mem_r[rp_r];

endmodule

// File: src/eadcm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eadcm_back
// Three pipelined rotation steps on the running matrix, then transpose.
// ----------------------------------------------------------------------------
module eadcm_back
  import eadcm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_vld,
  input  cmd_t      cmd,
  output logic      out_vld,
  output out_item_t out_item
);

  function automatic mat_t elem_mat(input rot_t r);
    mat_t e;
    e = '{default: '0};
    e[0] = ONE_Q; e[4] = ONE_Q; e[8] = ONE_Q;
    unique case (r.axis)
      AXIS_X: begin e[4] = r.c; e[5] = r.s; e[7] = -r.s; e[8] = r.c; end
      AXIS_Y: begin e[0] = r.c; e[2] = -r.s; e[6] = r.s; e[8] = r.c; end
      AXIS_Z: begin e[0] = r.c; e[1] = r.s; e[3] = -r.s; e[4] = r.c; end
      default: ;
    endcase
    return e;
  endfunction

  mat_t m_r [1:3];
  cmd_t c_r [2];
  logic [2:0] v_r;
  mat_t m0, e1, e2;

  // first step on identity is exact, so its matrix is the elementary one
  always_comb begin
    m0 = elem_mat(cmd.r0);
    e1 = elem_mat(c_r[0].r1);
    e2 = elem_mat(c_r[1].r2);
  end

  always_ff @(posedge clk) begin
    c_r[0] <= cmd;
    c_r[1] <= c_r[0];
    m_r[1] <= m0;
  end

  for (genvar k = 0; k < 2; k++) begin : g_mul
    always_ff @(posedge clk) begin
      for (int r = 0; r < 3; r++)
        for (int j = 0; j < 3; j++)
          m_r[k+2][r*3+j] <= round_clamp(
            36'((k == 0 ? e1[r*3] : e2[r*3]) * m_r[k+1][j])
            + 36'((k == 0 ? e1[r*3+1] : e2[r*3+1]) * m_r[k+1][3+j])
            + 36'((k == 0 ? e1[r*3+2] : e2[r*3+2]) * m_r[k+1][6+j]),
            FRACTION_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else v_r <= {v_r[1:0], cmd_vld};
  end

  assign out_vld = v_r[2];
  assign out_item = '{elem_r0c0: m_r[3][0], elem_r0c1: m_r[3][3], elem_r0c2: m_r[3][6],
                      elem_r1c0: m_r[3][1], elem_r1c1: m_r[3][4], elem_r1c2: m_r[3][7],
                      elem_r2c0: m_r[3][2], elem_r2c1: m_r[3][5], elem_r2c2: m_r[3][8]};

endmodule
